// File: rtl/fdr_pkg.sv
`timescale 1ns / 1ps
package fdr_pkg;

  localparam int MAX_NODES_DEF  = 256;
  localparam int COORD_BITS_DEF = 32;
  localparam int ACC_BITS       = 48;
  localparam int MAG_BITS       = 21;
  localparam int SQ_BITS        = 44;
  localparam int ROOT_BITS      = 22;
  localparam int DIV_BITS       = 44;
  localparam int CFG_AW         = 4;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_LINK   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SPRING     = 2'd1;
  localparam logic [1:0] REG_REPULSION  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LNK_P,
    S_LNK_D,
    S_LNK_M,
    S_LNK_A,
    S_FIN_P,
    S_FIN_RD,
    S_FIN_D,
    S_FIN_SQ,
    S_FIN_SUM,
    S_FIN_SQRT,
    S_FIN_DD,
    S_FIN_Q,
    S_FIN_QW,
    S_FIN_PROD,
    S_FIN_AX,
    S_FIN_AXW,
    S_EMIT
  } fdr_state_t;

endpackage

// File: rtl/fdr_if.sv
`timescale 1ns / 1ps
interface fdr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  node_index;
  logic [7:0]  neighbor_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, action, node_index, neighbor_index, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, action, node_index, neighbor_index, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface fdr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_index;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] new_z;

  modport source (output valid, out_index, new_x, new_y, new_z, input ready);
  modport sink (input valid, out_index, new_x, new_y, new_z, output ready);
endinterface

// File: rtl/fdr_store.sv
`timescale 1ns / 1ps
module fdr_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/fdr_div.sv
`timescale 1ns / 1ps
module fdr_div #(
  parameter int W = 44
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic          done,
  output logic [W-1:0]  quo
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem_r;
  logic [W-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    rem_s;
  logic          take;

  assign rem_s = {rem_r[W-1:0], num_r[W-1]};
  assign take  = rem_s >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? rem_s - {1'b0, den_r} : rem_s;
      num_r <= {num_r[W-2:0], 1'b0};
      quo_r <= {quo_r[W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// File: rtl/fdr_sqrt.sv
`timescale 1ns / 1ps
module fdr_sqrt #(
  parameter int W = 44
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     val,
  output logic             done,
  output logic [W/2-1:0]   root
);
  localparam int RW = W / 2;
  localparam int CW = $clog2(RW + 1);

  logic [W-1:0]  rad_r;
  logic [RW+1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW+1:0] rem_s;
  logic [RW+1:0] trial;
  logic          take;

  assign rem_s = {rem_r[RW-1:0], rad_r[W-1:W-2]};
  assign trial = {root_r, 2'b01};
  assign take  = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[W-3:0], 2'b00};
      rem_r  <= take ? rem_s - trial : rem_s;
      root_r <= {root_r[RW-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: rtl/force_directed_node_relax.sv
`timescale 1ns / 1ps
// Load: stored as the request is taken. Link: two store reads, difference,
// multiply, accumulate. Finish: each other node below the node count runs one 22-step
// square root and four 44-step divisions on one shared divider; far pairs skip them.
// One request at a time; a result waits in the output register while the next
// request is taken. Synchronous reset clears control and the force accumulator;
// the position store is not cleared and holds garbage until loaded.
module force_directed_node_relax #(
  parameter int MAX_NODES  = fdr_pkg::MAX_NODES_DEF,
  parameter int COORD_BITS = fdr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  fdr_in_if.sink                    in_chan,
  fdr_out_if.source                 out_chan,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fdr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fdr_pkg::*;

  localparam int IW   = $clog2(MAX_NODES);
  localparam int JW   = $clog2(MAX_NODES + 1);
  localparam int DW   = COORD_BITS + 1;
  localparam int SUMW = ((DW + 1 > ACC_BITS) ? DW + 1 : ACC_BITS) + 1;
  localparam int PW   = 3 * COORD_BITS;

  fdr_state_t state_r, state_nxt;

  logic [8:0]  node_count_r;
  logic [15:0] spring_r;
  logic [23:0] repulsion_r;

  logic [7:0] ni_r;
  logic [7:0] nb_r;
  logic [JW-1:0] j_r;
  logic [1:0] ax_r;
  logic rd_oob_r;

  logic signed [COORD_BITS-1:0] p_r [3];
  logic [DW-1:0] am_r [3];
  logic          neg_r [3];
  logic [DW-1:0] lk_r [3];
  logic [2*MAG_BITS-1:0] sq_r [3];
  logic signed [ACC_BITS-1:0] acc_r [3];
  logic [ROOT_BITS-1:0] d_r;
  logic [SQ_BITS-1:0]   dd_r;
  logic [ROOT_BITS-1:0] m_r;
  logic [DIV_BITS-1:0]  prod_r;

  logic        out_valid_r;
  logic [7:0]  out_index_r;
  logic [31:0] out_pos_r [3];

  // Control outputs.
  logic                accept;
  logic                in_rdy;
  logic [IW-1:0]       rd_addr;
  logic                rd_oob;
  logic                st_we;
  logic                div_start;
  logic                div_done;
  logic                sq_start;
  logic                sq_done;
  logic [DIV_BITS-1:0] div_num;
  logic [DIV_BITS-1:0] div_den;
  logic [DIV_BITS-1:0] div_quo;
  logic [SQ_BITS-1:0]  sq_val;
  logic [ROOT_BITS-1:0] sq_root;
  logic                emit;

  logic [PW-1:0] st_wdata;
  logic [PW-1:0] st_rdata;
  logic signed [COORD_BITS-1:0] o_pos [3];
  logic signed [COORD_BITS-1:0] ld_pos [3];
  logic [31:0] in_pos [3];
  logic signed [DW-1:0] d_val [3];
  logic [DW-1:0] d_mag [3];
  logic [2:0] far_ax;
  logic [JW-1:0] n_lim;
  logic last_j;
  logic self_j;
  logic signed [ACC_BITS-1:0] acc_nxt [3];
  logic [31:0] emit_pos [3];

  assign in_pos[0] = in_chan.pos_x;
  assign in_pos[1] = in_chan.pos_y;
  assign in_pos[2] = in_chan.pos_z;

  assign accept = in_chan.valid & in_rdy;
  assign in_chan.ready = in_rdy;
  assign n_lim = (32'(node_count_r) > 32'(MAX_NODES)) ? JW'(MAX_NODES) : JW'(node_count_r);
  assign last_j = j_r >= n_lim;
  assign self_j = 32'(j_r) == 32'(ni_r);

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 9'd1;
      spring_r     <= '0;
      repulsion_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_NODE_COUNT: node_count_r <= pwdata[8:0];
        REG_SPRING:     spring_r     <= pwdata[15:0];
        REG_REPULSION:  repulsion_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NODE_COUNT: prdata = 32'(node_count_r);
      REG_SPRING:     prdata = 32'(spring_r);
      REG_REPULSION:  prdata = 32'(repulsion_r);
      default:        prdata = '0;
    endcase
  end

  // Per-axis datapath.
  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [SUMW-1:0] add_v;
    logic signed [SUMW-1:0] sum;
    logic [SUMW-1:0]        add_m;
    logic                   add_en;
    logic                   add_neg;
    logic signed [SUMW-1:0] pos_sum;
    logic signed [COORD_BITS-1:0] pos_c;

    if (COORD_BITS >= 32) begin : g_ld
      assign ld_pos[a] = COORD_BITS'($signed(in_pos[a]));
    end else begin : g_ld_sat
      assign ld_pos[a] = (&in_pos[a][31:COORD_BITS-1] || ~|in_pos[a][31:COORD_BITS-1]) ?
                         in_pos[a][COORD_BITS-1:0] :
                         (in_pos[a][31] ? {1'b1, {(COORD_BITS-1){1'b0}}} :
                                          {1'b0, {(COORD_BITS-1){1'b1}}});
    end

    assign o_pos[a] = rd_oob_r ? '0 : st_rdata[a*COORD_BITS +: COORD_BITS];
    assign d_val[a] = DW'(o_pos[a]) - DW'(p_r[a]);
    assign d_mag[a] = d_val[a][DW-1] ? DW'(-d_val[a]) : DW'(d_val[a]);
    assign far_ax[a] = {{(64-DW){1'b0}}, d_mag[a]} >= (64'd1 << MAG_BITS);

    always_comb begin
      add_en  = 1'b0;
      add_neg = neg_r[a];
      add_m   = SUMW'(lk_r[a]);
      if (state_r == S_LNK_A) begin
        add_en = 1'b1;
      end else if (state_r == S_FIN_AXW && div_done && ax_r == 2'(a)) begin
        add_en = 1'b1;
        add_m  = SUMW'(div_quo);
      end
    end

    assign add_v = add_neg ? -$signed(add_m) : $signed(add_m);
    assign sum   = SUMW'(acc_r[a]) + add_v;
    assign acc_nxt[a] = (&sum[SUMW-1:ACC_BITS-1] || ~|sum[SUMW-1:ACC_BITS-1]) ?
                        sum[ACC_BITS-1:0] :
                        (sum[SUMW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}} :
                                       {1'b0, {(ACC_BITS-1){1'b1}}});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[a] <= '0;
      end else if (emit) begin
        acc_r[a] <= '0;
      end else if (add_en) begin
        acc_r[a] <= acc_nxt[a];
      end
    end

    assign pos_sum = SUMW'(p_r[a]) + SUMW'(acc_r[a]);
    assign pos_c = (&pos_sum[SUMW-1:COORD_BITS-1] || ~|pos_sum[SUMW-1:COORD_BITS-1]) ?
                   pos_sum[COORD_BITS-1:0] :
                   (pos_sum[SUMW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} :
                                      {1'b0, {(COORD_BITS-1){1'b1}}});
    if (COORD_BITS > 32) begin : g_out_sat
      assign emit_pos[a] = (&pos_c[COORD_BITS-1:31] || ~|pos_c[COORD_BITS-1:31]) ?
                           pos_c[31:0] :
                           (pos_c[COORD_BITS-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    end else begin : g_out
      assign emit_pos[a] = 32'(pos_c);
    end

    assign st_wdata[a*COORD_BITS +: COORD_BITS] = ld_pos[a];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_chan.action == ACT_LINK) state_nxt = S_LNK_P;
          else if (in_chan.action == ACT_FINISH) state_nxt = S_FIN_P;
          else state_nxt = S_IDLE;
        end
      end
      S_LNK_P:    state_nxt = S_LNK_D;
      S_LNK_D:    state_nxt = S_LNK_M;
      S_LNK_M:    state_nxt = S_LNK_A;
      S_LNK_A:    state_nxt = S_IDLE;
      S_FIN_P:    state_nxt = S_FIN_RD;
      S_FIN_RD: begin
        priority if (last_j) state_nxt = S_EMIT;
        else if (self_j) state_nxt = S_FIN_RD;
        else state_nxt = S_FIN_D;
      end
      S_FIN_D:    state_nxt = (|far_ax) ? S_FIN_RD : S_FIN_SQ;
      S_FIN_SQ:   state_nxt = S_FIN_SUM;
      S_FIN_SUM:  state_nxt = S_FIN_SQRT;
      S_FIN_SQRT: state_nxt = sq_done ? S_FIN_DD : S_FIN_SQRT;
      S_FIN_DD:   state_nxt = S_FIN_Q;
      S_FIN_Q:    state_nxt = S_FIN_QW;
      S_FIN_QW:   state_nxt = div_done ? S_FIN_PROD : S_FIN_QW;
      S_FIN_PROD: state_nxt = S_FIN_AX;
      S_FIN_AX:   state_nxt = S_FIN_AXW;
      S_FIN_AXW: begin
        if (div_done) state_nxt = (ax_r == 2'd2) ? S_FIN_RD : S_FIN_PROD;
      end
      S_EMIT:     state_nxt = (!out_valid_r || out_chan.ready) ? S_IDLE : S_EMIT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_rdy    = 1'b0;
    rd_addr   = IW'(in_chan.node_index);
    rd_oob    = 32'(in_chan.node_index) >= 32'(MAX_NODES);
    st_we     = 1'b0;
    div_start = 1'b0;
    div_num   = prod_r;
    div_den   = DIV_BITS'(d_r);
    sq_start  = 1'b0;
    sq_val    = SQ_BITS'(sq_r[0]) + SQ_BITS'(sq_r[1]) + SQ_BITS'(sq_r[2]);
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        st_we  = accept && in_chan.action == ACT_LOAD &&
                 32'(in_chan.node_index) < 32'(MAX_NODES);
      end
      S_LNK_P: begin
        rd_addr = IW'(nb_r);
        rd_oob  = 32'(nb_r) >= 32'(MAX_NODES);
      end
      S_FIN_RD: begin
        rd_addr = IW'(j_r);
        rd_oob  = 1'b0;
      end
      S_FIN_SUM: sq_start = 1'b1;
      S_FIN_Q: begin
        div_start = 1'b1;
        div_num   = DIV_BITS'({repulsion_r, 16'h0000});
        div_den   = dd_r;
      end
      S_FIN_AX:  div_start = 1'b1;
      S_EMIT:    emit = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_oob_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_oob_r <= rd_oob;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ni_r <= in_chan.node_index;
      nb_r <= in_chan.neighbor_index;
    end
    unique case (state_r)
      S_LNK_P, S_FIN_P: begin
        for (int a = 0; a < 3; a++) p_r[a] <= o_pos[a];
        j_r <= '0;
      end
      S_LNK_D: begin
        for (int a = 0; a < 3; a++) begin
          am_r[a]  <= d_mag[a];
          neg_r[a] <= d_val[a][DW-1];
        end
      end
      S_LNK_M: begin
        for (int a = 0; a < 3; a++) begin
          lk_r[a] <= DW'((({16'h0000, am_r[a]} * {{DW{1'b0}}, spring_r})) >> 16);
        end
      end
      S_FIN_RD: begin
        if (!last_j && self_j) j_r <= j_r + 1'b1;
      end
      S_FIN_D: begin
        for (int a = 0; a < 3; a++) begin
          am_r[a]  <= d_mag[a];
          neg_r[a] <= !d_val[a][DW-1] && (d_val[a] != '0);
        end
        if (|far_ax) j_r <= j_r + 1'b1;
      end
      S_FIN_SQ: begin
        for (int a = 0; a < 3; a++) begin
          sq_r[a] <= MAG_BITS'(am_r[a]) * MAG_BITS'(am_r[a]);
        end
      end
      S_FIN_SQRT: begin
        if (sq_done) d_r <= (sq_root == '0) ? ROOT_BITS'(1) : sq_root;
      end
      S_FIN_DD: dd_r <= SQ_BITS'(d_r) * SQ_BITS'(d_r);
      S_FIN_QW: begin
        if (div_done) begin
          m_r  <= (div_quo < DIV_BITS'(d_r)) ? ROOT_BITS'(div_quo) : d_r;
          ax_r <= 2'd0;
        end
      end
      S_FIN_PROD: prod_r <= DIV_BITS'({{ROOT_BITS{1'b0}}, MAG_BITS'(am_r[ax_r])} *
                                      {{MAG_BITS{1'b0}}, m_r});
      S_FIN_AXW: begin
        if (div_done) begin
          ax_r <= ax_r + 1'b1;
          if (ax_r == 2'd2) j_r <= j_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_index_r <= ni_r;
      for (int a = 0; a < 3; a++) out_pos_r[a] <= emit_pos[a];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_index = out_index_r;
  assign out_chan.new_x     = out_pos_r[0];
  assign out_chan.new_y     = out_pos_r[1];
  assign out_chan.new_z     = out_pos_r[2];

  fdr_store #(
    .DEPTH (MAX_NODES),
    .WIDTH (PW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (IW'(in_chan.node_index)),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  fdr_sqrt #(
    .W (SQ_BITS)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  fdr_div #(
    .W (DIV_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );
endmodule

// File: tb/sv/force_directed_node_relax_test.sv
`timescale 1ns / 1ps
module force_directed_node_relax_test;
  import fdr_pkg::*;

  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int HANG_LIMIT = 250000;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } relaxed_pos_t;

  class relax_scoreboard;
    longint nodes [256][3];
    longint force_sum [3];
    longint node_cnt;
    longint spring_k;
    longint repel_k;
    relaxed_pos_t pending_pos [$];
    int errors;

    function new();
      node_cnt = 1;
      spring_k = 0;
      repel_k = 0;
      errors = 0;
      for (int a = 0; a < 3; a++) force_sum[a] = 0;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function void add_force(int a, longint m, bit neg);
      force_sum[a] = clamp(force_sum[a] + (neg ? -m : m), ACC_BITS);
    endfunction

    function longint root(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function void repel_from(int ni, int j);
      longint d [3];
      longint am [3];
      longint ss, span, q, m;
      ss = 0;
      for (int a = 0; a < 3; a++) begin
        d[a] = nodes[j][a] - nodes[ni][a];
        am[a] = d[a] < 0 ? -d[a] : d[a];
        if (am[a] >= (64'sd1 <<< 21)) return;
      end
      for (int a = 0; a < 3; a++) ss += am[a] * am[a];
      span = root(ss);
      if (span < 1) span = 1;
      q = (repel_k <<< 16) / (span * span);
      m = q < span ? q : span;
      for (int a = 0; a < 3; a++) add_force(a, (am[a] * m) / span, d[a] > 0);
    endfunction

    function void set_reg(logic [1:0] r, longint v);
      case (r)
        REG_NODE_COUNT: node_cnt = v & 'h1FF;
        REG_SPRING: spring_k = v & 'hFFFF;
        REG_REPULSION: repel_k = v & 'hFFFFFF;
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] act, int ni, int nb,
                               logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint d, n;
      relaxed_pos_t r;
      case (act)
        ACT_LOAD: begin
          nodes[ni][0] = longint'($signed(px));
          nodes[ni][1] = longint'($signed(py));
          nodes[ni][2] = longint'($signed(pz));
        end
        ACT_LINK: begin
          for (int a = 0; a < 3; a++) begin
            d = nodes[nb][a] - nodes[ni][a];
            add_force(a, ((d < 0 ? -d : d) * spring_k) >>> 16, d < 0);
          end
        end
        ACT_FINISH: begin
          n = node_cnt > 256 ? 256 : node_cnt;
          for (int j = 0; j < n; j++)
            if (j != ni) repel_from(ni, j);
          r.idx = 8'(ni);
          r.x = 32'(clamp(nodes[ni][0] + force_sum[0], 32));
          r.y = 32'(clamp(nodes[ni][1] + force_sum[1], 32));
          r.z = 32'(clamp(nodes[ni][2] + force_sum[2], 32));
          for (int a = 0; a < 3; a++) force_sum[a] = 0;
          pending_pos.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(relaxed_pos_t got);
      relaxed_pos_t want;
      if (pending_pos.size() == 0) begin
        $display("%0t: unexpected result idx=%0d x=%h y=%h z=%h",
                 $time, got.idx, got.x, got.y, got.z);
        errors++;
        return;
      end
      want = pending_pos.pop_front();
      if (got.idx !== want.idx) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: new_x expected %h actual %h", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: new_y expected %h actual %h", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: new_z expected %h actual %h", $time, want.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fdr_in_if in_bus ();
  fdr_out_if out_bus ();

  force_directed_node_relax dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_bus),
    .out_chan(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  relax_scoreboard sb = new();
  bit tx_busy, rx_busy;
  bit loaded [256];
  int loaded_list [$];
  int sent;
  int idle_cycles;
  longint cur_nc;
  int cluster_base;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_LOAD;
    in_bus.node_index = '0;
    in_bus.neighbor_index = '0;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.pos_z = '0;
  end

  // while rx_busy is set, hold ready low for a drawn number of cycles (possibly none) after each result
  initial begin : result_sink
    int hold;
    relaxed_pos_t got;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.idx = out_bus.out_index;
        got.x = out_bus.new_x;
        got.y = out_bus.new_y;
        got.z = out_bus.new_z;
        sb.check_result(got);
        hold = rx_busy ? $urandom_range(0, 8) : 0;
        if (hold > 0) out_bus.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_bus.ready <= 1'b1;
      end else if (rst_n) begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("force_directed_node_relax verification failed");
      $finish;
    end
  end

  task automatic push_request(logic [1:0] act, int ni, int nb,
                              logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    gap = tx_busy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.node_index <= 8'(ni);
    in_bus.neighbor_index <= 8'(nb);
    in_bus.pos_x <= px;
    in_bus.pos_y <= py;
    in_bus.pos_z <= pz;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_request(act, ni, nb, px, py, pz);
    if (act == ACT_LOAD && !loaded[ni]) begin
      loaded[ni] = 1'b1;
      loaded_list.push_back(ni);
    end
    sent++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending_pos.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic set_config(longint nc, longint spring, longint rep);
    write_reg(REG_NODE_COUNT, 32'(nc));
    write_reg(REG_SPRING, 32'(spring));
    write_reg(REG_REPULSION, 32'(rep));
    cur_nc = nc;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return cluster_base + $urandom_range(0, 8191) - 4096;
  endfunction

  task automatic load_node(int ni);
    push_request(ACT_LOAD, ni, $urandom_range(0, 255), rand_coord(), rand_coord(),
                 rand_coord());
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic random_phase(int count, int finish_budget);
    int kind, ni;
    longint n;
    n = cur_nc > 256 ? 256 : cur_nc;
    for (int j = 0; j < n; j++)
      if (!loaded[j]) load_node(j);
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        ni = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        load_node(ni);
      end else if (kind < 75 || (kind < 95 && finish_budget == 0)) begin
        push_request(ACT_LINK, pick_loaded(), pick_loaded(), $urandom(), $urandom(),
                     $urandom());
      end else if (kind < 95) begin
        push_request(ACT_FINISH, pick_loaded(), $urandom_range(0, 255), $urandom(),
                     $urandom(), $urandom());
        finish_budget--;
      end else begin
        push_request(ACT_IDLE, $urandom_range(0, 255), $urandom_range(0, 255), $urandom(),
                     $urandom(), $urandom());
      end
    end
    push_request(ACT_FINISH, pick_loaded(), 0, '0, '0, '0);
    drain();
  endtask

  initial begin
    longint nc_list [9] = '{0, 1, 3, 8, 5, 2, 256, 511, 7};
    sent = 0;
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    cluster_base = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(4, 65535, 24'hFFFFFF);
    push_request(ACT_LOAD, 0, 0, 32'd0, 32'd0, 32'd0);
    push_request(ACT_LOAD, 1, 0, 32'd256, 32'd0, 32'd0);
    push_request(ACT_LOAD, 2, 0, 32'd0, 32'd0, 32'd0);
    push_request(ACT_LOAD, 3, 255, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    push_request(ACT_LOAD, 255, 255, 32'h80000000, 32'h7FFFFFFF, 32'd0);
    push_request(ACT_LINK, 0, 1, '0, '0, '0);
    push_request(ACT_FINISH, 0, 0, '0, '0, '0);
    push_request(ACT_LINK, 3, 255, '0, '0, '0);
    push_request(ACT_LINK, 3, 255, '0, '0, '0);
    push_request(ACT_FINISH, 3, 0, '0, '0, '0);
    push_request(ACT_LINK, 255, 3, '0, '0, '0);
    push_request(ACT_LINK, 255, 3, '0, '0, '0);
    push_request(ACT_FINISH, 255, 0, '0, '0, '0);
    push_request(ACT_IDLE, 255, 255, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_request(ACT_LINK, 1, 1, '0, '0, '0);
    push_request(ACT_FINISH, 1, 0, '0, '0, '0);
    push_request(ACT_FINISH, 2, 0, '0, '0, '0);
    drain();
    set_config(0, 0, 0);
    push_request(ACT_LINK, 1, 0, '0, '0, '0);
    push_request(ACT_FINISH, 2, 0, '0, '0, '0);
    drain();

    for (int p = 0; p < 9; p++) begin
      tx_busy = (p % 3) != 0;
      rx_busy = (p % 3) != 1;
      cluster_base = $urandom_range(0, 1 << 20) - (1 << 19);
      set_config(nc_list[p], (p % 4 == 0) ? 65535 : $urandom_range(0, 65535),
                 (p % 4 == 1) ? 24'hFFFFFF : (p % 4 == 2) ? 0 : $urandom_range(0, 24'hFFFFFF));
      random_phase(nc_list[p] > 16 ? 30 : 70, nc_list[p] > 16 ? 1 : 100);
    end
    set_config(6, 0, $urandom_range(1, 24'hFFFFFF));
    while (sent < 700) random_phase(40, 100);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("force_directed_node_relax verification clean");
    else
      $display("force_directed_node_relax verification failed");
    $finish;
  end

endmodule
